// ----- src/adsr_pkg.sv -----
// adsr_pkg: shared constants, register codes and the pipeline divider stage type
// no dependencies
package adsr_pkg;

  localparam int TimeBits  = 32;
  localparam int LevelBits = 16;
  localparam int TickBits  = 24;
  localparam int IdxBits   = 3;
  localparam int DataBits  = 32;
  // numerator width of either division: tick count times level
  localparam int NumBits   = TickBits + LevelBits;
  localparam int DivSteps  = NumBits;
  // side data carried beside each divider stage, sized for the widest user
  localparam int SideBits  = 3 + LevelBits + TimeBits;
  localparam logic [LevelBits-1:0] FloorLevel =
    LevelBits'((64'd1 << (LevelBits - 1)) / 64'd10000);

  localparam logic [IdxBits-1:0] RegAttack  = 3'd0;
  localparam logic [IdxBits-1:0] RegDecay   = 3'd1;
  localparam logic [IdxBits-1:0] RegRelease = 3'd2;
  localparam logic [IdxBits-1:0] RegSustain = 3'd3;
  localparam logic [IdxBits-1:0] RegStart   = 3'd4;

  // one restoring-division stage: remainder, quotient, divisor
  typedef struct packed {
    logic [NumBits:0]   rem;
    logic [NumBits-1:0] quo;
    logic [TickBits-1:0] div;
  } div_word_t;

endpackage

// ----- src/adsr_envelope_level.sv -----
// adsr_envelope_level: top level, linear adsr envelope level per input word
// depends on adsr_pkg and adsr_div
//
//  channel | signals                              | direction
//  in      | in_valid, in_stall, held, since_on, since_off | into block
//  out     | out_valid, out_stall, level          | out of block
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | into block
//
// one word accepted per cycle while in_stall is low
// the two pipelined dividers (40 stages each) form most of the pipeline
// whole pipeline advances when the output register is empty or being taken
// rst synchronous, clears valid bits and reloads register reset values
module adsr_envelope_level (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               held,
  input  logic [adsr_pkg::TimeBits-1:0]      since_on,
  input  logic [adsr_pkg::TimeBits-1:0]      since_off,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [adsr_pkg::LevelBits-1:0]     level,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [adsr_pkg::IdxBits-1:0]       cfg_index,
  input  logic [adsr_pkg::DataBits-1:0]      cfg_data
);
  localparam int TB = adsr_pkg::TickBits;
  localparam int LB = adsr_pkg::LevelBits;
  localparam int NB = adsr_pkg::NumBits;
  localparam int WB = adsr_pkg::TimeBits;

  // configuration registers
  logic [TB-1:0] attack_ticks, decay_ticks, release_ticks;
  logic [LB-1:0] sustain_level, start_level;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks  <= TB'(4410);
      decay_ticks   <= TB'(441);
      release_ticks <= TB'(8820);
      sustain_level <= LB'(26214);
      start_level   <= LB'(32768);
    end else if (cfg_valid) begin
      case (cfg_index)
        adsr_pkg::RegAttack:  attack_ticks  <= cfg_data[TB-1:0];
        adsr_pkg::RegDecay:   decay_ticks   <= cfg_data[TB-1:0];
        adsr_pkg::RegRelease: release_ticks <= cfg_data[TB-1:0];
        adsr_pkg::RegSustain: sustain_level <= cfg_data[LB-1:0];
        adsr_pkg::RegStart:   start_level   <= cfg_data[LB-1:0];
        default: ;
      endcase
    end
  end

  // pipeline advances whenever the output register can take a word
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stage 1: phase compare, capture of times
  typedef enum logic [1:0] {PH_ATTACK, PH_DECAY, PH_SUSTAIN} phase_t;
  logic          v1, h1;
  phase_t        ph1;
  logic [WB-1:0] on1;
  logic [WB-1:0] off1;
  logic [WB:0]   ad_sum;
  assign ad_sum = {1'b0, WB'(attack_ticks)} + {1'b0, WB'(decay_ticks)};

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      h1   <= held;
      on1  <= since_on;
      off1 <= since_off;
      if (since_on <= WB'(attack_ticks)) ph1 <= PH_ATTACK;
      else if ({1'b0, since_on} <= ad_sum) ph1 <= PH_DECAY;
      else ph1 <= PH_SUSTAIN;
    end
  end

  // stage 2: build numerator and divisor for the hold-phase division
  logic          v2, h2, down2, bypass2;
  logic [LB-1:0] base2;
  logic [NB-1:0] num2;
  logic [TB-1:0] den2;
  logic [WB-1:0] off2;
  logic [LB-1:0] diff;
  logic [WB-1:0] dt;
  assign diff = (start_level >= sustain_level) ? start_level - sustain_level
                                               : sustain_level - start_level;
  assign dt   = on1 - WB'(attack_ticks);

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      h2   <= h1;
      off2 <= off1;
      case (ph1)
        PH_ATTACK: begin
          // t <= attack fits in tick width
          num2    <= NB'(on1[TB-1:0]) * NB'(start_level);
          den2    <= attack_ticks;
          bypass2 <= (attack_ticks == '0);
          base2   <= (attack_ticks == '0) ? start_level : '0;
          down2   <= 1'b0;
        end
        PH_DECAY: begin
          num2    <= NB'(dt[TB-1:0]) * NB'(diff);
          den2    <= decay_ticks;
          bypass2 <= 1'b0;
          base2   <= start_level;
          down2   <= (start_level >= sustain_level);
        end
        default: begin
          num2    <= '0;
          den2    <= TB'(1);
          bypass2 <= 1'b1;
          base2   <= sustain_level;
          down2   <= 1'b0;
        end
      endcase
    end
  end

  // first divider; side data carries what the later stages need
  localparam int S1 = adsr_pkg::SideBits;
  logic          v3;
  logic [NB-1:0] q3;
  logic [S1-1:0] side3;
  adsr_div u_div_hold (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2),
    .num(num2), .den(den2),
    .side_in({h2, down2, bypass2, base2, off2}),
    .out_valid(v3), .quo(q3), .side_out(side3)
  );
  logic          h3, down3, bypass3;
  logic [LB-1:0] base3;
  logic [WB-1:0] off3;
  assign {h3, down3, bypass3, base3, off3} = side3;

  // stage 4: held level, then release numerator
  logic [LB-1:0] hl;
  always_comb begin
    if (bypass3)    hl = base3;
    else if (down3) hl = base3 - q3[LB-1:0];
    else            hl = base3 + q3[LB-1:0];
  end

  logic          v4, pass4, zero4;
  logic [LB-1:0] hl4;
  logic [NB-1:0] num4;
  logic [TB-1:0] den4;
  logic          rel_zero;
  assign rel_zero = (release_ticks == '0) || (off3 >= WB'(release_ticks));

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      hl4   <= hl;
      pass4 <= h3;
      zero4 <= !h3 && rel_zero;
      num4  <= NB'(hl) * NB'(release_ticks - off3[TB-1:0]);
      den4  <= (h3 || rel_zero) ? TB'(1) : release_ticks;
    end
  end

  // second divider; only the low side bits are in use
  localparam int S2 = 2 + LB;
  logic          v5;
  logic [NB-1:0] q5;
  logic [S1-1:0] side5;
  adsr_div u_div_rel (
    .clk(clk), .rst(rst), .en(en), .in_valid(v4),
    .num(num4), .den(den4),
    .side_in({{(S1 - S2){1'b0}}, pass4, zero4, hl4}),
    .out_valid(v5), .quo(q5), .side_out(side5)
  );
  logic          pass5, zero5;
  logic [LB-1:0] hl5, fin;
  assign {pass5, zero5, hl5} = side5[S2-1:0];

  always_comb begin
    if (zero5)      fin = '0;
    else if (pass5) fin = hl5;
    else            fin = q5[LB-1:0];
    if (fin <= adsr_pkg::FloorLevel) fin = '0;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v5;
    if (en) level <= fin;
  end

`ifndef SYNTHESIS
  a_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (level == '0 || level > adsr_pkg::FloorLevel))
    else $error("level inside floor band");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(level)))
    else $error("stalled word changed");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output backpressure");
`endif
endmodule

// ----- src/adsr_div.sv -----
// adsr_div: pipelined unsigned divider, one quotient bit per stage
// depends on adsr_pkg; side data rides beside each stage
module adsr_div (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic [adsr_pkg::NumBits-1:0]      num,
  input  logic [adsr_pkg::TickBits-1:0]     den,
  input  logic [adsr_pkg::SideBits-1:0]     side_in,
  output logic                              out_valid,
  output logic [adsr_pkg::NumBits-1:0]      quo,
  output logic [adsr_pkg::SideBits-1:0]     side_out
);
  localparam int N = adsr_pkg::DivSteps;

  adsr_pkg::div_word_t st [N+1];
  logic [adsr_pkg::SideBits-1:0] sd [N+1];
  logic [N:0]          vl;

  always_comb begin
    st[0].rem = '0;
    st[0].quo = num;
    st[0].div = den;
    sd[0]     = side_in;
    vl[0]     = in_valid;
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [adsr_pkg::NumBits:0] shifted;
    logic [adsr_pkg::NumBits:0] trial;
    always_comb begin
      shifted = {st[i].rem[adsr_pkg::NumBits-1:0], st[i].quo[adsr_pkg::NumBits-1]};
      trial   = shifted - {{(adsr_pkg::NumBits + 1 - adsr_pkg::TickBits){1'b0}}, st[i].div};
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
      if (en) begin
        sd[i+1]     <= sd[i];
        st[i+1].div <= st[i].div;
        if (!trial[adsr_pkg::NumBits]) begin
          st[i+1].rem <= trial;
          st[i+1].quo <= {st[i].quo[adsr_pkg::NumBits-2:0], 1'b1};
        end else begin
          st[i+1].rem <= shifted;
          st[i+1].quo <= {st[i].quo[adsr_pkg::NumBits-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = vl[N];
  assign quo       = st[N].quo;
  assign side_out  = sd[N];
endmodule
